>>> sv/page_frame_replacement_engine_assert.svh
// assertion macros for the page frame replacement engine
// clocked by clock, disabled while reset is high
`ifndef PAGE_FRAME_REPLACEMENT_ENGINE_ASSERT_SVH
`define PAGE_FRAME_REPLACEMENT_ENGINE_ASSERT_SVH

// same-cycle implication
`define PFRE_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PFRE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/pfre_pkg.sv
// shared types, sizes and codes of the page frame replacement engine
// no dependencies
`timescale 1ns / 1ps

package pfre_pkg;

   localparam int FRAMES        = 256;
   localparam int PROCESS_SLOTS = 64;

   localparam int FRAME_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int CNT_W   = FRAME_W + 2;
   localparam int SLOT_W  = (PROCESS_SLOTS > 1) ? $clog2(PROCESS_SLOTS) : 1;
   localparam int SCNT_W  = SLOT_W + 1;
   localparam int FREED_W = FRAME_W + 1;

   localparam int PID_W   = 16;
   localparam int PAGE_W  = 22;
   localparam int USE_W   = 16;
   localparam int ADDR_W  = 32;
   localparam int TOTAL_W = 32;

   localparam logic [15:0] HALF_PERIOD_RESET = 16'd5000;
   localparam logic [4:0]  PAGE_SHIFT_RESET  = 5'd12;
   localparam logic [4:0]  PAGE_SHIFT_MIN    = 5'd10;
   localparam logic [15:0] SEED_RESET        = 16'd44257;
   localparam logic [15:0] LFSR_TAPS         = 16'hB400;

   localparam logic [2:0] ST_HIT        = 3'd0;
   localparam logic [2:0] ST_FILL       = 3'd1;
   localparam logic [2:0] ST_CLEAN_EVICT = 3'd2;
   localparam logic [2:0] ST_DIRTY_EVICT = 3'd3;
   localparam logic [2:0] ST_REFUSED    = 3'd4;
   localparam logic [2:0] ST_TERMINATED = 3'd5;

   localparam logic [1:0] POL_SECOND_CHANCE = 2'd0;
   localparam logic [1:0] POL_LEAST_USED    = 2'd1;

   localparam logic [1:0] CSR_POLICY      = 2'd0;
   localparam logic [1:0] CSR_HALF_PERIOD = 2'd1;
   localparam logic [1:0] CSR_PAGE_SHIFT  = 2'd2;
   localparam logic [1:0] CSR_SEED        = 2'd3;

   localparam logic ACT_TERMINATE = 1'b1;

   typedef struct packed {
      logic [PID_W-1:0]  owner;
      logic [PAGE_W-1:0] page;
      logic              dirty;
      logic              referenced;
      logic [USE_W-1:0]  use_count;
   } frame_entry_type;

   localparam int ENTRY_W = $bits(frame_entry_type);

endpackage

>>> sv/pfre_ram.sv
// simple dual port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module pfre_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

>>> sv/page_frame_replacement_engine.sv
// page frame replacement engine: a request runs an aging sweep over every frame when
// the aging period has run out, a sweep of the process slots, a scan of the frame table
// and, if no hit or free frame is found, a victim search; termination sweeps the slots and
// every frame. one request at a time. synchronous active-high reset clears all valid bits,
// the fault and sweep counters and the configuration registers at once; no clearing pass
`timescale 1ns / 1ps
`include "page_frame_replacement_engine_assert.svh"

module page_frame_replacement_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_action,
   input  logic [15:0] req_pid,
   input  logic [31:0] req_address,
   input  logic        req_write,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_frame,
   output logic [15:0] rsp_evicted_pid,
   output logic [21:0] rsp_evicted_page,
   output logic [8:0]  rsp_dirty_freed,
   output logic [31:0] rsp_read_faults,
   output logic [31:0] rsp_writeback_faults,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int FW = pfre_pkg::FRAME_W;
   localparam int SW = pfre_pkg::SLOT_W;

   typedef enum logic [3:0] {
      S_IDLE, S_AGE, S_SLOT, S_SCAN, S_HIT, S_SC, S_VREAD, S_VCAP,
      S_INSTALL, S_TERM, S_DONE
   } state_type;

   state_type state_ff;

   logic [1:0]  policy_ff;
   logic [15:0] half_period_ff;
   logic [4:0]  page_shift_ff;
   logic [15:0] lfsr_ff;

   logic                        action_ff;
   logic [pfre_pkg::PID_W-1:0]  pid_ff;
   logic [pfre_pkg::PAGE_W-1:0] page_ff;
   logic                        write_ff;

   logic [pfre_pkg::FRAMES-1:0]        fvalid_ff;
   logic [pfre_pkg::PROCESS_SLOTS-1:0] svalid_ff;
   logic [pfre_pkg::CNT_W-1:0]         cnt_ff;
   logic [pfre_pkg::SCNT_W-1:0]        scnt_ff;
   logic [FW-1:0]                      last_ff;
   logic [15:0]                        period_ff;
   logic [pfre_pkg::TOTAL_W-1:0]       clean_ff;
   logic [pfre_pkg::TOTAL_W-1:0]       dirty_ff;

   logic          known_ff, free_f_ff, term_hit_ff;
   logic [SW-1:0] free_i_ff;
   logic          emp_f_ff;
   logic [FW-1:0] emp_i_ff, best_ff, victim_ff;
   logic [16:0]   min_ff;
   logic          evict_ff;
   logic [pfre_pkg::FREED_W-1:0] freed_ff;
   pfre_pkg::frame_entry_type    entry_ff;

   logic [2:0]  res_status_ff;
   logic [15:0] res_evpid_ff;
   logic [21:0] res_evpage_ff;

   logic        rsp_valid_ff;
   logic [2:0]  rsp_status_ff;
   logic [7:0]  rsp_frame_ff;
   logic [15:0] rsp_evpid_ff;
   logic [21:0] rsp_evpage_ff;
   logic [8:0]  rsp_freed_ff;
   logic [31:0] rsp_rfaults_ff;
   logic [31:0] rsp_wfaults_ff;

   // frame and slot ram ports
   logic                       fr_we;
   logic [FW-1:0]              fr_waddr, fr_raddr;
   pfre_pkg::frame_entry_type  fr_wdata, fr_rdata;
   logic [pfre_pkg::ENTRY_W-1:0] fr_rdata_raw;
   logic                       sl_we;
   logic [SW-1:0]              sl_waddr, sl_raddr;
   logic [pfre_pkg::PID_W-1:0] sl_rdata;

   // combinational evaluation of the entry returned this cycle
   logic [pfre_pkg::CNT_W-1:0] efull;
   logic [FW-1:0]              eidx, sc_e;
   logic [SW-1:0]              seidx;
   logic                       eval, seval, sc_pass, sc_take, hit_now;
   logic                       known_in, free_f_in, term_hit_in, slot_clear;
   logic [SW-1:0]              free_i_in;
   logic                       emp_f_in;
   logic [FW-1:0]              emp_i_in, best_in;
   logic [16:0]                min_in;
   logic [pfre_pkg::FREED_W-1:0] freed_in;
   logic [15:0]                lfsr_in, period_in;
   logic [4:0]                 shift_in;
   logic [pfre_pkg::PAGE_W-1:0] page_in;
   logic                       rsp_free;

   pfre_ram #(.WIDTH(pfre_pkg::ENTRY_W), .DEPTH(pfre_pkg::FRAMES)) u_frame_ram (
      .clock   (clock),
      .wr_en   (fr_we),
      .wr_addr (fr_waddr),
      .wr_data (fr_wdata),
      .rd_addr (fr_raddr),
      .rd_data (fr_rdata_raw)
   );
   assign fr_rdata = pfre_pkg::frame_entry_type'(fr_rdata_raw);

   pfre_ram #(.WIDTH(pfre_pkg::PID_W), .DEPTH(pfre_pkg::PROCESS_SLOTS)) u_slot_ram (
      .clock   (clock),
      .wr_en   (sl_we),
      .wr_addr (sl_waddr),
      .wr_data (pid_ff),
      .rd_addr (sl_raddr),
      .rd_data (sl_rdata)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   assign efull   = cnt_ff - 1'b1;
   assign eidx    = efull[FW-1:0];
   assign sc_pass = efull[FW];
   assign sc_e    = last_ff + eidx;
   assign seidx   = SW'(scnt_ff - 1'b1);
   assign eval    = (cnt_ff != '0);
   assign seval   = (scnt_ff != '0);

   assign lfsr_in  = (lfsr_ff >> 1) ^ (lfsr_ff[0] ? pfre_pkg::LFSR_TAPS : 16'd0);
   assign period_in = period_ff + 16'd1;
   assign shift_in = (page_shift_ff < pfre_pkg::PAGE_SHIFT_MIN) ?
                     pfre_pkg::PAGE_SHIFT_MIN : page_shift_ff;
   assign page_in  = pfre_pkg::PAGE_W'(req_address >> shift_in);

   assign sc_take = fvalid_ff[sc_e] && !fr_rdata.referenced && (sc_pass || !fr_rdata.dirty);
   assign hit_now = (state_ff == S_SCAN) && eval && fvalid_ff[eidx] &&
                    (fr_rdata.owner == pid_ff) && (fr_rdata.page == page_ff);

   always_comb begin
      known_in    = known_ff;
      free_f_in   = free_f_ff;
      free_i_in   = free_i_ff;
      term_hit_in = term_hit_ff;
      slot_clear  = 1'b0;
      if ((state_ff == S_SLOT) && seval) begin
         if (svalid_ff[seidx] && (sl_rdata == pid_ff)) begin
            known_in = 1'b1;
            if (!term_hit_ff) begin
               term_hit_in = 1'b1;
               slot_clear  = (action_ff == pfre_pkg::ACT_TERMINATE);
            end
         end else if (!svalid_ff[seidx] && !free_f_ff) begin
            free_f_in = 1'b1;
            free_i_in = seidx;
         end
      end
   end

   always_comb begin
      emp_f_in = emp_f_ff;
      emp_i_in = emp_i_ff;
      min_in   = min_ff;
      best_in  = best_ff;
      freed_in = freed_ff;
      if ((state_ff == S_SCAN) && eval) begin
         if (!fvalid_ff[eidx] && !emp_f_ff) begin
            emp_f_in = 1'b1;
            emp_i_in = eidx;
         end
         if (fvalid_ff[eidx] && ({1'b0, fr_rdata.use_count} < min_ff)) begin
            min_in  = {1'b0, fr_rdata.use_count};
            best_in = eidx;
         end
      end
      if ((state_ff == S_TERM) && eval && fvalid_ff[eidx] &&
          (fr_rdata.owner == pid_ff) && fr_rdata.dirty) begin
         freed_in = freed_ff + 1'b1;
      end
   end

   always_comb begin
      fr_raddr = cnt_ff[FW-1:0];
      fr_we    = 1'b0;
      fr_waddr = eidx;
      fr_wdata = fr_rdata;
      sl_raddr = scnt_ff[SW-1:0];
      sl_we    = 1'b0;
      sl_waddr = free_i_in;
      case (state_ff)
         S_AGE: begin
            if (eval && fvalid_ff[eidx]) begin
               fr_we = 1'b1;
               fr_wdata.use_count  = fr_rdata.use_count >> 1;
               fr_wdata.referenced = 1'b0;
            end
         end
         S_SLOT: begin
            sl_we = (scnt_ff == pfre_pkg::SCNT_W'(pfre_pkg::PROCESS_SLOTS)) &&
                    (action_ff != pfre_pkg::ACT_TERMINATE) && !known_in && free_f_in;
         end
         S_SC: begin
            fr_raddr = last_ff + cnt_ff[FW-1:0];
            fr_waddr = sc_e;
            if (eval && fvalid_ff[sc_e] && !sc_take) begin
               fr_we = 1'b1;
               fr_wdata.referenced = 1'b0;
            end
         end
         S_VREAD: begin
            fr_raddr = victim_ff;
         end
         S_HIT: begin
            fr_we    = 1'b1;
            fr_waddr = victim_ff;
            fr_wdata = entry_ff;
            fr_wdata.referenced = 1'b1;
            fr_wdata.dirty      = entry_ff.dirty | write_ff;
            if (entry_ff.use_count != '1) begin
               fr_wdata.use_count = entry_ff.use_count + 1'b1;
            end
         end
         S_INSTALL: begin
            fr_we    = 1'b1;
            fr_waddr = victim_ff;
            fr_wdata.owner      = pid_ff;
            fr_wdata.page       = page_ff;
            fr_wdata.dirty      = write_ff;
            fr_wdata.referenced = 1'b1;
            fr_wdata.use_count  = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         policy_ff      <= pfre_pkg::POL_SECOND_CHANCE;
         half_period_ff <= pfre_pkg::HALF_PERIOD_RESET;
         page_shift_ff  <= pfre_pkg::PAGE_SHIFT_RESET;
         lfsr_ff        <= pfre_pkg::SEED_RESET;
         fvalid_ff      <= '0;
         svalid_ff      <= '0;
         last_ff        <= '0;
         period_ff      <= '0;
         clean_ff       <= '0;
         dirty_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
         cnt_ff         <= '0;
         scnt_ff        <= '0;
      end else begin
         if (rsp_valid_ff && rsp_ready && (state_ff != S_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               pfre_pkg::CSR_POLICY:      policy_ff      <= csr_data[1:0];
               pfre_pkg::CSR_HALF_PERIOD: half_period_ff <= csr_data;
               pfre_pkg::CSR_PAGE_SHIFT:  page_shift_ff  <= csr_data[4:0];
               pfre_pkg::CSR_SEED:        lfsr_ff <= (csr_data == '0) ? 16'd1 : csr_data;
               default: begin
               end
            endcase
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid && req_ready) begin
                  action_ff     <= req_action;
                  pid_ff        <= req_pid;
                  page_ff       <= page_in;
                  write_ff      <= req_write;
                  victim_ff     <= '0;
                  res_evpid_ff  <= '0;
                  res_evpage_ff <= '0;
                  freed_ff      <= '0;
                  known_ff      <= 1'b0;
                  free_f_ff     <= 1'b0;
                  free_i_ff     <= '0;
                  term_hit_ff   <= 1'b0;
                  cnt_ff        <= '0;
                  scnt_ff       <= '0;
                  if ((req_action != pfre_pkg::ACT_TERMINATE) &&
                      (period_in >= half_period_ff)) begin
                     period_ff <= '0;
                     state_ff  <= S_AGE;
                  end else begin
                     if (req_action != pfre_pkg::ACT_TERMINATE) begin
                        period_ff <= period_in;
                     end
                     state_ff <= S_SLOT;
                  end
               end
            end
            S_AGE: begin
               if (cnt_ff == pfre_pkg::CNT_W'(pfre_pkg::FRAMES)) begin
                  cnt_ff   <= '0;
                  state_ff <= S_SLOT;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            S_SLOT: begin
               known_ff    <= known_in;
               free_f_ff   <= free_f_in;
               free_i_ff   <= free_i_in;
               term_hit_ff <= term_hit_in;
               if (slot_clear) begin
                  svalid_ff[seidx] <= 1'b0;
               end
               if (scnt_ff == pfre_pkg::SCNT_W'(pfre_pkg::PROCESS_SLOTS)) begin
                  cnt_ff   <= '0;
                  emp_f_ff <= 1'b0;
                  emp_i_ff <= '0;
                  min_ff   <= 17'h10000;
                  best_ff  <= '0;
                  if (action_ff == pfre_pkg::ACT_TERMINATE) begin
                     state_ff <= S_TERM;
                  end else if (known_in) begin
                     state_ff <= S_SCAN;
                  end else if (free_f_in) begin
                     svalid_ff[free_i_in] <= 1'b1;
                     state_ff <= S_SCAN;
                  end else begin
                     res_status_ff <= pfre_pkg::ST_REFUSED;
                     state_ff      <= S_DONE;
                  end
               end else begin
                  scnt_ff <= scnt_ff + 1'b1;
               end
            end
            S_SCAN: begin
               emp_f_ff <= emp_f_in;
               emp_i_ff <= emp_i_in;
               min_ff   <= min_in;
               best_ff  <= best_in;
               if (hit_now) begin
                  victim_ff <= eidx;
                  entry_ff  <= fr_rdata;
                  state_ff  <= S_HIT;
               end else if (cnt_ff == pfre_pkg::CNT_W'(pfre_pkg::FRAMES)) begin
                  cnt_ff <= '0;
                  if (emp_f_in) begin
                     victim_ff <= emp_i_in;
                     evict_ff  <= 1'b0;
                     state_ff  <= S_INSTALL;
                  end else begin
                     case (policy_ff)
                        pfre_pkg::POL_SECOND_CHANCE: begin
                           state_ff <= S_SC;
                        end
                        pfre_pkg::POL_LEAST_USED: begin
                           victim_ff <= best_in;
                           state_ff  <= S_VREAD;
                        end
                        default: begin
                           lfsr_ff   <= lfsr_in;
                           victim_ff <= lfsr_in[FW-1:0];
                           state_ff  <= S_VREAD;
                        end
                     endcase
                  end
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            S_HIT: begin
               res_status_ff <= pfre_pkg::ST_HIT;
               state_ff      <= S_DONE;
            end
            S_SC: begin
               if (eval && sc_take) begin
                  victim_ff <= sc_e;
                  entry_ff  <= fr_rdata;
                  evict_ff  <= 1'b1;
                  state_ff  <= S_INSTALL;
               end else if (cnt_ff == pfre_pkg::CNT_W'(2 * pfre_pkg::FRAMES)) begin
                  victim_ff <= last_ff;
                  state_ff  <= S_VREAD;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            S_VREAD: begin
               state_ff <= S_VCAP;
            end
            S_VCAP: begin
               entry_ff <= fr_rdata;
               evict_ff <= 1'b1;
               state_ff <= S_INSTALL;
            end
            S_INSTALL: begin
               fvalid_ff[victim_ff] <= 1'b1;
               last_ff <= victim_ff;
               if (evict_ff) begin
                  res_evpid_ff  <= entry_ff.owner;
                  res_evpage_ff <= entry_ff.page;
                  if (entry_ff.dirty) begin
                     dirty_ff      <= dirty_ff + 1'b1;
                     res_status_ff <= pfre_pkg::ST_DIRTY_EVICT;
                  end else begin
                     clean_ff      <= clean_ff + 1'b1;
                     res_status_ff <= pfre_pkg::ST_CLEAN_EVICT;
                  end
               end else begin
                  clean_ff      <= clean_ff + 1'b1;
                  res_status_ff <= pfre_pkg::ST_FILL;
               end
               state_ff <= S_DONE;
            end
            S_TERM: begin
               freed_ff <= freed_in;
               if (eval && fvalid_ff[eidx] && (fr_rdata.owner == pid_ff)) begin
                  fvalid_ff[eidx] <= 1'b0;
               end
               if (cnt_ff == pfre_pkg::CNT_W'(pfre_pkg::FRAMES)) begin
                  dirty_ff      <= dirty_ff + pfre_pkg::TOTAL_W'(freed_in);
                  res_status_ff <= pfre_pkg::ST_TERMINATED;
                  state_ff      <= S_DONE;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            S_DONE: begin
               if (rsp_free) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_status_ff  <= res_status_ff;
                  rsp_frame_ff   <= ((res_status_ff == pfre_pkg::ST_REFUSED) ||
                                     (res_status_ff == pfre_pkg::ST_TERMINATED)) ?
                                    8'd0 : 8'(victim_ff);
                  rsp_evpid_ff   <= res_evpid_ff;
                  rsp_evpage_ff  <= res_evpage_ff;
                  rsp_freed_ff   <= 9'(freed_ff);
                  rsp_rfaults_ff <= clean_ff;
                  rsp_wfaults_ff <= dirty_ff;
                  state_ff       <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_frame            = rsp_frame_ff;
   assign rsp_evicted_pid      = rsp_evpid_ff;
   assign rsp_evicted_page     = rsp_evpage_ff;
   assign rsp_dirty_freed      = rsp_freed_ff;
   assign rsp_read_faults      = rsp_rfaults_ff;
   assign rsp_writeback_faults = rsp_wfaults_ff;

   `PFRE_ASSERT_NEXT(a_accept_leaves_idle, req_valid && req_ready, !req_ready, "accept did not start work")
   `PFRE_ASSERT_NEXT(a_done_delivers, (state_ff == S_DONE) && rsp_free, rsp_valid_ff, "result beat lost")
   `PFRE_ASSERT_NOW(a_no_rw_collision, fr_we && ((state_ff == S_AGE) || (state_ff == S_SC)), fr_waddr != fr_raddr, "frame ram read and write collide")
   `PFRE_ASSERT_NEXT(a_install_sets_valid, state_ff == S_INSTALL, fvalid_ff[$past(victim_ff)], "installed frame not valid")

endmodule
